### rtl/core/mx_pkg.sv
`default_nettype none

package mx_pkg;

    localparam int FIELD_W  = 31;
    localparam int EXP_BITS = 31;
    localparam int MOD_BITS = 31;
    localparam int STEP_W   = 4;
    localparam int CNT_W    = $clog2(EXP_BITS + 1);
    localparam int MCNT_W   = $clog2(FIELD_W + 1);
    localparam int CFG_IDX_W = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_EXPONENT = 1'b0,
        REG_MODULUS  = 1'b1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        JMP_NONE,
        JMP_ALWAYS,
        JMP_IDLE,
        JMP_MUL_BUSY,
        JMP_BIT_CLR,
        JMP_MORE_BITS
    } jmp_cond_t;

    typedef enum logic [1:0] {
        OP_REDUCE,
        OP_ACC_POW,
        OP_POW_POW
    } mul_op_t;

    typedef struct packed {
        jmp_cond_t          cond;
        logic [STEP_W-1:0]  target;
        logic               load;
        logic               mul_go;
        mul_op_t            op;
        logic               wb;
        logic               shift;
        logic               done;
    } ctrl_word_t;

    typedef struct packed {
        logic start;
        logic mul_busy;
        logic exp_bit;
        logic more_bits;
    } seq_flags_t;

    localparam logic [STEP_W-1:0] S_IDLE     = 4'd0;
    localparam logic [STEP_W-1:0] S_RED_GO   = 4'd1;
    localparam logic [STEP_W-1:0] S_RED_WAIT = 4'd2;
    localparam logic [STEP_W-1:0] S_TEST     = 4'd3;
    localparam logic [STEP_W-1:0] S_MUL_GO   = 4'd4;
    localparam logic [STEP_W-1:0] S_MUL_WAIT = 4'd5;
    localparam logic [STEP_W-1:0] S_SQR_GO   = 4'd6;
    localparam logic [STEP_W-1:0] S_SQR_WAIT = 4'd7;
    localparam logic [STEP_W-1:0] S_NEXT     = 4'd8;
    localparam logic [STEP_W-1:0] S_DONE     = 4'd9;

    // Microprogram: reduce the base, then per exponent bit an optional
    // multiply into the accumulator followed by a squaring of the power.
    function automatic ctrl_word_t ucode_rom(input logic [STEP_W-1:0] step);
        ctrl_word_t w;
        w = '{cond: JMP_NONE, target: S_IDLE, load: 1'b0, mul_go: 1'b0,
              op: OP_REDUCE, wb: 1'b0, shift: 1'b0, done: 1'b0};
        case (step)
            S_IDLE:
            begin
                w.cond   = JMP_IDLE;
                w.target = S_IDLE;
                w.load   = 1'b1;
            end
            S_RED_GO:
            begin
                w.mul_go = 1'b1;
                w.op     = OP_REDUCE;
            end
            S_RED_WAIT:
            begin
                w.cond   = JMP_MUL_BUSY;
                w.target = S_RED_WAIT;
                w.op     = OP_REDUCE;
                w.wb     = 1'b1;
            end
            S_TEST:
            begin
                w.cond   = JMP_BIT_CLR;
                w.target = S_SQR_GO;
            end
            S_MUL_GO:
            begin
                w.mul_go = 1'b1;
                w.op     = OP_ACC_POW;
            end
            S_MUL_WAIT:
            begin
                w.cond   = JMP_MUL_BUSY;
                w.target = S_MUL_WAIT;
                w.op     = OP_ACC_POW;
                w.wb     = 1'b1;
            end
            S_SQR_GO:
            begin
                w.mul_go = 1'b1;
                w.op     = OP_POW_POW;
            end
            S_SQR_WAIT:
            begin
                w.cond   = JMP_MUL_BUSY;
                w.target = S_SQR_WAIT;
                w.op     = OP_POW_POW;
                w.wb     = 1'b1;
            end
            S_NEXT:
            begin
                w.cond   = JMP_MORE_BITS;
                w.target = S_TEST;
                w.shift  = 1'b1;
            end
            S_DONE:
            begin
                w.cond   = JMP_ALWAYS;
                w.target = S_IDLE;
                w.done   = 1'b1;
            end
            default:
            begin
                w.cond   = JMP_ALWAYS;
                w.target = S_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

### rtl/core/mx_mulmod.sv
`default_nettype none

module mx_mulmod (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         go,
    input  wire logic [mx_pkg::MOD_BITS-1:0]  a,
    input  wire logic [mx_pkg::FIELD_W-1:0]   b,
    input  wire logic [mx_pkg::MOD_BITS:0]    m,
    output logic                              busy,
    output logic [mx_pkg::MOD_BITS-1:0]       prod
);
    import mx_pkg::*;

    localparam int PW = MOD_BITS + 2;

    logic [MCNT_W-1:0]   cnt_reg, cnt_next;
    logic [MOD_BITS-1:0] acc_reg, acc_next;
    logic [MOD_BITS-1:0] a_reg, a_next;
    logic [FIELD_W-1:0]  b_reg, b_next;
    logic [PW-1:0]       mm, t1, t1r, t2, t2r;

    // Interleaved reduction: acc = (2*acc + bit*a) mod m, multiplier MSB first
    always_comb
    begin
        mm  = {1'b0, m};
        t1  = {1'b0, acc_reg, 1'b0};
        t1r = (t1 >= mm) ? (t1 - mm) : t1;
        t2  = t1r + (b_reg[FIELD_W-1] ? {2'b00, a_reg} : {PW{1'b0}});
        t2r = (t2 >= mm) ? (t2 - mm) : t2;
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        acc_next = acc_reg;
        a_next   = a_reg;
        b_next   = b_reg;
        if (go)
        begin
            cnt_next = MCNT_W'(FIELD_W);
            acc_next = '0;
            a_next   = a;
            b_next   = b;
        end
        else if (busy)
        begin
            cnt_next = cnt_reg - 1'b1;
            acc_next = t2r[MOD_BITS-1:0];
            b_next   = {b_reg[FIELD_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
    end

    assign busy = (cnt_reg != '0);
    assign prod = acc_reg;

endmodule

`default_nettype wire

### rtl/core/mx_seq.sv
`default_nettype none

module mx_seq (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire mx_pkg::seq_flags_t  flags,
    output mx_pkg::ctrl_word_t       ctrl,
    output logic                     busy
);
    import mx_pkg::*;

    logic [STEP_W-1:0] step_reg, step_next;
    logic              taken;

    assign ctrl = ucode_rom(step_reg);

    always_comb
    begin
        case (ctrl.cond)
            JMP_NONE:      taken = 1'b0;
            JMP_ALWAYS:    taken = 1'b1;
            JMP_IDLE:      taken = !flags.start;
            JMP_MUL_BUSY:  taken = flags.mul_busy;
            JMP_BIT_CLR:   taken = !flags.exp_bit;
            JMP_MORE_BITS: taken = flags.more_bits;
            default:       taken = 1'b1;
        endcase
        step_next = taken ? ctrl.target : (step_reg + 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= S_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    assign busy = (step_reg != S_IDLE);

endmodule

`default_nettype wire

### rtl/core/modular_exponentiation.sv
`default_nettype none

// Modular exponentiation: power_result = base_value ^ exponent mod modulus.
// Configure exponent (index 0) and modulus (index 1) through cfg_we,
// cfg_index and cfg_data while busy is low; a write takes effect at once.
// Start an item by raising start with base_value while busy is low; the
// transfer happens at that edge and busy rises on the next cycle.
// The result is shown on power_result for exactly one cycle with done high;
// the receiver cannot stall, so it must take it then.
// After the transfer edge, the base is reduced once, then each of the 31
// exponent bits costs a squaring plus two sequencer steps and a set bit
// adds one multiplication; every modular multiplication runs on the shared
// bit-serial multiplier (31 shift-add-reduce steps), and a final step
// registers the result. One item at a time; the next item may transfer in
// the cycle done is high.
// An exponent of zero gives 1; a modulus of zero acts as 2^31.
// Reset returns the sequencer to idle, clears done and sets the exponent to
// 0 and the modulus to 1.
module modular_exponentiation (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [mx_pkg::FIELD_W-1:0]     base_value,
    output logic                                done,
    output logic [mx_pkg::FIELD_W-1:0]          power_result,
    input  wire logic                           cfg_we,
    input  wire logic [mx_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [mx_pkg::FIELD_W-1:0]     cfg_data
);
    import mx_pkg::*;

    ctrl_word_t          ctrl;
    seq_flags_t          flags;
    logic                seq_busy;

    logic [FIELD_W-1:0]  exponent_reg;
    logic [FIELD_W-1:0]  modulus_reg;
    logic [FIELD_W-1:0]  exp_reg, exp_next;
    logic [CNT_W-1:0]    bit_cnt_reg, bit_cnt_next;
    logic [MOD_BITS-1:0] acc_reg, acc_next;
    logic [FIELD_W-1:0]  pow_reg, pow_next;
    logic                done_reg;
    logic [FIELD_W-1:0]  result_reg;

    logic [MOD_BITS:0]   mod_eff;
    logic [MOD_BITS-1:0] mul_a;
    logic                mul_busy;
    logic [MOD_BITS-1:0] mul_prod;

    mx_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctrl  (ctrl),
        .busy  (seq_busy)
    );

    mx_mulmod u_mulmod (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (ctrl.mul_go),
        .a     (mul_a),
        .b     (pow_reg),
        .m     (mod_eff),
        .busy  (mul_busy),
        .prod  (mul_prod)
    );

    // A zero modulus wraps to 2^MOD_BITS
    always_comb
    begin
        if (modulus_reg[MOD_BITS-1:0] == '0)
        begin
            mod_eff = {1'b1, {MOD_BITS{1'b0}}};
        end
        else
        begin
            mod_eff = {1'b0, modulus_reg[MOD_BITS-1:0]};
        end
    end

    always_comb
    begin
        case (ctrl.op)
            OP_REDUCE:  mul_a = MOD_BITS'(1);
            OP_ACC_POW: mul_a = acc_reg;
            OP_POW_POW: mul_a = pow_reg[MOD_BITS-1:0];
            default:    mul_a = acc_reg;
        endcase
    end

    always_comb
    begin
        flags.start     = start;
        flags.mul_busy  = mul_busy;
        flags.exp_bit   = exp_reg[0];
        flags.more_bits = (bit_cnt_reg != CNT_W'(1));
    end

    always_comb
    begin
        exp_next     = exp_reg;
        bit_cnt_next = bit_cnt_reg;
        acc_next     = acc_reg;
        pow_next     = pow_reg;
        if (ctrl.load && start)
        begin
            exp_next     = exponent_reg;
            bit_cnt_next = CNT_W'(EXP_BITS);
            acc_next     = MOD_BITS'(1);
            pow_next     = base_value;
        end
        if (ctrl.wb && !mul_busy)
        begin
            case (ctrl.op)
                OP_ACC_POW: acc_next = mul_prod;
                OP_REDUCE:  pow_next = FIELD_W'(mul_prod);
                OP_POW_POW: pow_next = FIELD_W'(mul_prod);
                default:    pow_next = pow_reg;
            endcase
        end
        if (ctrl.shift)
        begin
            exp_next     = exp_reg >> 1;
            bit_cnt_next = bit_cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exponent_reg <= '0;
            modulus_reg  <= FIELD_W'(1);
            done_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_EXPONENT: exponent_reg <= cfg_data;
                    REG_MODULUS:  modulus_reg  <= cfg_data;
                    default:      exponent_reg <= exponent_reg;
                endcase
            end
            done_reg <= ctrl.done;
        end
    end

    always_ff @(posedge clk)
    begin
        exp_reg     <= exp_next;
        bit_cnt_reg <= bit_cnt_next;
        acc_reg     <= acc_next;
        pow_reg     <= pow_next;
        if (ctrl.done)
        begin
            result_reg <= FIELD_W'(acc_reg);
        end
    end

    assign busy         = seq_busy;
    assign done         = done_reg;
    assign power_result = result_reg;

`ifndef SYNTHESIS
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while an item is in progress");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not start the sequencer");

    a_mul_in_item: assert property (@(posedge clk) disable iff (!rst_n)
        mul_busy |-> busy)
        else $error("multiplier running outside an item");
`endif

endmodule

`default_nettype wire
